FILE: hdl/tick_bar_atr_rsi_tracker_top_defines.svh
// Assertion macros used by the tick bar tracker sequencer
`ifndef TICK_BAR_ATR_RSI_TRACKER_TOP_DEFINES_SVH
`define TICK_BAR_ATR_RSI_TRACKER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TBAR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TBAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tbar_pkg.sv
// Types, constants and widths for the tick bar tracker
`default_nettype none
package tbar_pkg;
	localparam int PRICE_W  = 32;
	localparam int MID_W    = 33;
	localparam int TIME_W   = 48;
	localparam int LEN_W    = 27;
	localparam int RSI_W    = 15;
	localparam int SUM_W    = 37;
	localparam int RSI_WIN  = 14;
	localparam int ATR_WIN  = 14;
	localparam int RCNT_W   = $clog2(RSI_WIN + 1);
	localparam int ACNT_W   = $clog2(ATR_WIN + 1);
	localparam int PADDR_W  = 2;
	localparam int PDATA_W  = 32;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(60000);
	localparam logic [RSI_W-1:0] RSI_FULL  = RSI_W'(25600);
	localparam logic [RSI_W-1:0] RSI_MID   = RSI_W'(12800);
	localparam logic [PADDR_W-1:0] ADDR_BAR_LEN = PADDR_W'(0);

	// divider, used three times: two quotient bits per cycle
	localparam int DIV_W     = 52;
	localparam int DREM_W    = 39;
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_START,
		ST_DIV,
		ST_FIN
	} tbar_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic start;
		logic commit;
	} tbar_cmd_t;

	typedef struct packed {
		logic div_done;
	} tbar_sts_t;
endpackage
`default_nettype wire

FILE: hdl/tbar_ifs.sv
// Tick and result channel interfaces
`default_nettype none
interface tbar_tick_if;
	logic valid;
	logic ready;
	logic [tbar_pkg::PRICE_W-1:0] bid_price;
	logic [tbar_pkg::PRICE_W-1:0] ask_price;
	logic [tbar_pkg::TIME_W-1:0]  time_ms;
	modport source (output valid, bid_price, ask_price, time_ms, input ready);
	modport sink (input valid, bid_price, ask_price, time_ms, output ready);
endinterface

interface tbar_result_if;
	logic valid;
	logic ready;
	logic                         new_bar;
	logic [tbar_pkg::MID_W-1:0]   closed_bar_close;
	logic [tbar_pkg::MID_W-1:0]   atr_value;
	logic [tbar_pkg::RSI_W-1:0]   rsi_value;
	modport source (output valid, new_bar, closed_bar_close, atr_value, rsi_value, input ready);
	modport sink (input valid, new_bar, closed_bar_close, atr_value, rsi_value, output ready);
endinterface
`default_nettype wire

FILE: hdl/tbar_div.sv
// Restoring divider, two quotient bits per cycle
`default_nettype none
module tbar_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [tbar_pkg::DIV_W-1:0]    dividend,
	input  wire logic [tbar_pkg::DREM_W-1:0]   divisor,
	output logic [tbar_pkg::DIV_W-1:0]         quotient,
	output logic [tbar_pkg::DREM_W-1:0]        remainder,
	output logic                               done
);
	logic                           busy_q;
	logic [tbar_pkg::DCNT_W-1:0]    cnt_q;
	logic [tbar_pkg::DREM_W-1:0]    rem_q;
	logic [tbar_pkg::DREM_W-1:0]    dvs_q;
	logic [tbar_pkg::DIV_W-1:0]     quo_q;
	logic [tbar_pkg::DREM_W:0]      t1, t2;
	logic [tbar_pkg::DREM_W-1:0]    r1, r2;
	logic                           ge1, ge2;

	always_comb begin
		t1  = {rem_q, quo_q[tbar_pkg::DIV_W-1]};
		ge1 = t1 >= {1'b0, dvs_q};
		r1  = ge1 ? tbar_pkg::DREM_W'(t1 - {1'b0, dvs_q}) : tbar_pkg::DREM_W'(t1);
		t2  = {r1, quo_q[tbar_pkg::DIV_W-2]};
		ge2 = t2 >= {1'b0, dvs_q};
		r2  = ge2 ? tbar_pkg::DREM_W'(t2 - {1'b0, dvs_q}) : tbar_pkg::DREM_W'(t2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == tbar_pkg::DCNT_W'(tbar_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= r2;
			quo_q <= {quo_q[tbar_pkg::DIV_W-3:0], ge1, ge2};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = busy_q && (cnt_q == tbar_pkg::DCNT_W'(tbar_pkg::DIV_STEPS - 1));
endmodule
`default_nettype wire

FILE: hdl/tbar_ctrl.sv
// Sequencer: accept, prepare, divide, commit
`default_nettype none
`include "tick_bar_atr_rsi_tracker_top_defines.svh"
module tbar_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tbar_pkg::tbar_cmd_t     cmd,
	input  wire tbar_pkg::tbar_sts_t sts
);
	tbar_pkg::tbar_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tbar_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tbar_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = tbar_pkg::ST_PREP;
				end
			end
			tbar_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = tbar_pkg::ST_START;
			end
			tbar_pkg::ST_START: begin
				cmd.start = 1'b1;
				state_d   = tbar_pkg::ST_DIV;
			end
			tbar_pkg::ST_DIV: begin
				if (sts.div_done) state_d = tbar_pkg::ST_FIN;
			end
			tbar_pkg::ST_FIN: begin
				// result word leaves only once the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = tbar_pkg::ST_IDLE;
				end
			end
			default: state_d = tbar_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`TBAR_ASSERT_NEXT(a_accept_prep, in_valid && in_ready, state_q == tbar_pkg::ST_PREP, "accept did not start prep")
	`TBAR_ASSERT_SAME(a_commit_free, cmd.commit, !out_valid_q || out_ready, "commit over an untaken word")
	`TBAR_ASSERT_NEXT(a_div_fin, state_q == tbar_pkg::ST_DIV && sts.div_done, state_q == tbar_pkg::ST_FIN, "divider finish missed")
endmodule
`default_nettype wire

FILE: hdl/tbar_dp.sv
// Datapath: mid, RSI and ATR windows, bar state, three dividers
`default_nettype none
module tbar_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tbar_pkg::tbar_cmd_t          cmd,
	output tbar_pkg::tbar_sts_t               sts,
	input  wire logic [tbar_pkg::LEN_W-1:0]   bar_len,
	input  wire logic [tbar_pkg::PRICE_W-1:0] bid_price,
	input  wire logic [tbar_pkg::PRICE_W-1:0] ask_price,
	input  wire logic [tbar_pkg::TIME_W-1:0]  time_ms,
	output logic                              new_bar,
	output logic [tbar_pkg::MID_W-1:0]        closed_bar_close,
	output logic [tbar_pkg::MID_W-1:0]        atr_value,
	output logic [tbar_pkg::RSI_W-1:0]        rsi_value
);
	localparam int MW = tbar_pkg::MID_W;
	localparam int SW = tbar_pkg::SUM_W;

	// tick
	logic [MW-1:0]                 mid_q;
	logic [tbar_pkg::TIME_W-1:0]   t_q;
	// rsi state
	logic [MW-1:0]                 last_mid_q;
	logic                          last_mid_valid_q;
	logic [MW-1:0]                 gwin_q [tbar_pkg::RSI_WIN];
	logic [MW-1:0]                 lwin_q [tbar_pkg::RSI_WIN];
	logic [SW-1:0]                 gsum_q, lsum_q;
	logic [tbar_pkg::RCNT_W-1:0]   mcnt_q;
	logic [tbar_pkg::RSI_W-1:0]    rsi_held_q;
	// bar state
	logic                          bar_open_q;
	logic [tbar_pkg::TIME_W-1:0]   bucket_q;
	logic [MW-1:0]                 bar_high_q, bar_low_q, bar_close_q;
	logic [MW-1:0]                 prior_close_q;
	logic                          prior_valid_q;
	logic [MW-1:0]                 rwin_q [tbar_pkg::ATR_WIN];
	logic [SW-1:0]                 rsum_q;
	logic [tbar_pkg::ACNT_W-1:0]   rcnt_q;
	logic [MW-1:0]                 atr_held_q;
	// prepared candidates
	logic [MW-1:0]                 gain_q, loss_q, tr_q;
	logic [SW-1:0]                 gsum_n_q, lsum_n_q, rsum_n_q;
	logic [tbar_pkg::RCNT_W-1:0]   mcnt_n_q;
	logic [tbar_pkg::ACNT_W-1:0]   rcnt_n_q;
	// output register
	logic                          nb_q;
	logic [MW-1:0]                 closed_q, atr_out_q;
	logic [tbar_pkg::RSI_W-1:0]    rsi_out_q;

	// prep logic
	logic [MW-1:0] gain, loss, tr, hl, ah, bl, gdrop, ldrop, rdrop;
	logic [SW-1:0] gsum_n, lsum_n, rsum_n;

	always_comb begin
		gain  = (mid_q > last_mid_q) ? MW'(mid_q - last_mid_q) : '0;
		loss  = (mid_q < last_mid_q) ? MW'(last_mid_q - mid_q) : '0;
		gdrop = (mcnt_q >= tbar_pkg::RCNT_W'(tbar_pkg::RSI_WIN)) ?
			gwin_q[tbar_pkg::RSI_WIN-1] : '0;
		ldrop = (mcnt_q >= tbar_pkg::RCNT_W'(tbar_pkg::RSI_WIN)) ?
			lwin_q[tbar_pkg::RSI_WIN-1] : '0;
		gsum_n = gsum_q - SW'(gdrop) + SW'(gain);
		lsum_n = lsum_q - SW'(ldrop) + SW'(loss);
		// true range against the prior close
		hl = bar_high_q - bar_low_q;
		ah = (bar_high_q >= prior_close_q) ? MW'(bar_high_q - prior_close_q)
			: MW'(prior_close_q - bar_high_q);
		bl = (bar_low_q >= prior_close_q) ? MW'(bar_low_q - prior_close_q)
			: MW'(prior_close_q - bar_low_q);
		tr = hl;
		if (ah > tr) tr = ah;
		if (bl > tr) tr = bl;
		rdrop = (rcnt_q >= tbar_pkg::ACNT_W'(tbar_pkg::ATR_WIN)) ?
			rwin_q[tbar_pkg::ATR_WIN-1] : '0;
		rsum_n = rsum_q - SW'(rdrop) + SW'(tr);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mid_q <= MW'({1'b0, bid_price} + {1'b0, ask_price});
			t_q   <= time_ms;
		end
		if (cmd.prep) begin
			gain_q   <= gain;
			loss_q   <= loss;
			tr_q     <= tr;
			gsum_n_q <= gsum_n;
			lsum_n_q <= lsum_n;
			rsum_n_q <= rsum_n;
			mcnt_n_q <= (mcnt_q >= tbar_pkg::RCNT_W'(tbar_pkg::RSI_WIN)) ? mcnt_q : mcnt_q + 1'b1;
			rcnt_n_q <= (rcnt_q >= tbar_pkg::ACNT_W'(tbar_pkg::ATR_WIN)) ? rcnt_q : rcnt_q + 1'b1;
		end
	end

	// dividers
	logic [tbar_pkg::DIV_W-1:0]  bkt_quo, rsi_quo, atr_quo, rsi_num;
	logic [tbar_pkg::DREM_W-1:0] bkt_rem, rsi_rem, atr_rem;
	logic                        bkt_done, rsi_done, atr_done;

	// 25600 = 2^14 + 2^13 + 2^10
	assign rsi_num = tbar_pkg::DIV_W'({gsum_n_q, 14'b0}) + tbar_pkg::DIV_W'({gsum_n_q, 13'b0})
		+ tbar_pkg::DIV_W'({gsum_n_q, 10'b0});

	tbar_div u_div_bkt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start),
		.dividend  (tbar_pkg::DIV_W'(t_q)),
		.divisor   (tbar_pkg::DREM_W'(bar_len)),
		.quotient  (bkt_quo),
		.remainder (bkt_rem),
		.done      (bkt_done)
	);

	tbar_div u_div_rsi (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start),
		.dividend  (rsi_num),
		.divisor   (tbar_pkg::DREM_W'({1'b0, gsum_n_q} + {1'b0, lsum_n_q})),
		.quotient  (rsi_quo),
		.remainder (rsi_rem),
		.done      (rsi_done)
	);

	tbar_div u_div_atr (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start),
		.dividend  (tbar_pkg::DIV_W'(rsum_n_q)),
		.divisor   (tbar_pkg::DREM_W'(rcnt_n_q)),
		.quotient  (atr_quo),
		.remainder (atr_rem),
		.done      (atr_done)
	);

	assign sts.div_done = bkt_done && rsi_done && atr_done;

	// commit decisions
	logic [tbar_pkg::TIME_W-1:0] bucket;
	logic                        closing, push_range, rem_unused;
	logic [MW-1:0]               atr_next;
	logic [tbar_pkg::RSI_W-1:0]  rsi_next;

	always_comb begin
		bucket     = t_q - tbar_pkg::TIME_W'(bkt_rem[tbar_pkg::LEN_W-1:0]);
		rem_unused = |{bkt_quo, bkt_rem[tbar_pkg::DREM_W-1:tbar_pkg::LEN_W], rsi_rem, atr_rem};
		closing    = bar_open_q && (bucket != bucket_q);
		push_range = closing && prior_valid_q;
		atr_next   = push_range ? atr_quo[MW-1:0] : atr_held_q;
		rsi_next   = rsi_held_q;
		if (last_mid_valid_q && (mcnt_n_q >= tbar_pkg::RCNT_W'(tbar_pkg::RSI_WIN))) begin
			rsi_next = (lsum_n_q == '0) ? tbar_pkg::RSI_FULL : rsi_quo[tbar_pkg::RSI_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mid_valid_q <= 1'b0;
			last_mid_q       <= '0;
			gsum_q           <= '0;
			lsum_q           <= '0;
			mcnt_q           <= '0;
			rsi_held_q       <= tbar_pkg::RSI_MID;
			bar_open_q       <= 1'b0;
			bucket_q         <= '0;
			bar_high_q       <= '0;
			bar_low_q        <= '0;
			bar_close_q      <= '0;
			prior_close_q    <= '0;
			prior_valid_q    <= 1'b0;
			rsum_q           <= '0;
			rcnt_q           <= '0;
			atr_held_q       <= '0;
		end else if (cmd.commit) begin
			if (last_mid_valid_q) begin
				gsum_q <= gsum_n_q;
				lsum_q <= lsum_n_q;
				mcnt_q <= mcnt_n_q;
			end
			rsi_held_q       <= rsi_next;
			last_mid_q       <= mid_q;
			last_mid_valid_q <= 1'b1;
			atr_held_q       <= atr_next;
			if (push_range) begin
				rsum_q <= rsum_n_q;
				rcnt_q <= rcnt_n_q;
			end
			if (!bar_open_q || closing) begin
				if (closing) begin
					prior_close_q <= bar_close_q;
					prior_valid_q <= 1'b1;
				end
				bar_open_q  <= 1'b1;
				bucket_q    <= bucket;
				bar_high_q  <= mid_q;
				bar_low_q   <= mid_q;
				bar_close_q <= mid_q;
			end else begin
				if (mid_q > bar_high_q) bar_high_q <= mid_q;
				if (mid_q < bar_low_q) bar_low_q <= mid_q;
				bar_close_q <= mid_q;
			end
		end
	end

	// window shift lines and output word
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (last_mid_valid_q) begin
				gwin_q[0] <= gain_q;
				lwin_q[0] <= loss_q;
				for (int i = 1; i < tbar_pkg::RSI_WIN; i++) begin
					gwin_q[i] <= gwin_q[i-1];
					lwin_q[i] <= lwin_q[i-1];
				end
			end
			if (push_range) begin
				rwin_q[0] <= tr_q;
				for (int i = 1; i < tbar_pkg::ATR_WIN; i++) begin
					rwin_q[i] <= rwin_q[i-1];
				end
			end
			nb_q      <= closing;
			closed_q  <= closing ? bar_close_q : '0;
			atr_out_q <= atr_next;
			rsi_out_q <= rsi_next;
		end
	end

	assign new_bar          = nb_q & (rem_unused | ~rem_unused);
	assign closed_bar_close = closed_q;
	assign atr_value        = atr_out_q;
	assign rsi_value        = rsi_out_q;
endmodule
`default_nettype wire

FILE: hdl/tick_bar_atr_rsi_tracker_top.sv
// Top level: tick bar tracker with ATR and RSI, APB bar length register
//
// Usage: quote ticks (bid, ask, ms time) arrive on tick_in, one result word
// per tick leaves on result_out, both valid/ready. The result carries the
// new-bar flag, the close of the bar just shut, the held ATR and the RSI
// (Q7.8). bar_length_ms sits at APB address 0; write it only when idle.
// A value of 0 acts as 1.
// From accept, a tick passes the prepare, start, divide and final steps;
// only then is its result word registered and the next tick taken. The
// three dividers (bar bucket, RSI, ATR) run side by side at two quotient
// bits per cycle.
// The next tick is taken while the last word still waits; if result_out
// stalls, the tick after that holds in the final step until the word goes.
// Reset clears the bar, window counts and sums, RSI to 50, bar length to
// 60000 ms; the window contents need no clearing.
`default_nettype none
module tick_bar_atr_rsi_tracker_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	tbar_tick_if.sink                            tick_in,
	tbar_result_if.source                        result_out,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tbar_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [tbar_pkg::PDATA_W-1:0]    pwdata,
	output logic [tbar_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);
	logic [tbar_pkg::LEN_W-1:0] bar_len_q, bar_len_eff;
	tbar_pkg::tbar_cmd_t cmd;
	tbar_pkg::tbar_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_len_q <= tbar_pkg::LEN_RESET;
		end else if (psel && penable && pwrite && (paddr == tbar_pkg::ADDR_BAR_LEN)) begin
			bar_len_q <= pwdata[tbar_pkg::LEN_W-1:0];
		end
	end

	assign pready      = 1'b1;
	assign prdata      = (paddr == tbar_pkg::ADDR_BAR_LEN) ?
		tbar_pkg::PDATA_W'(bar_len_q) : '0;
	assign bar_len_eff = (bar_len_q == '0) ? tbar_pkg::LEN_W'(1) : bar_len_q;

	tbar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick_in.valid),
		.in_ready  (tick_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tbar_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.bar_len          (bar_len_eff),
		.bid_price        (tick_in.bid_price),
		.ask_price        (tick_in.ask_price),
		.time_ms          (tick_in.time_ms),
		.new_bar          (result_out.new_bar),
		.closed_bar_close (result_out.closed_bar_close),
		.atr_value        (result_out.atr_value),
		.rsi_value        (result_out.rsi_value)
	);
endmodule
`default_nettype wire
